// File: design/hsv_pkg.sv
// Constants and helpers for the HSV to RGB pixel converter.
package hsv_pkg;

   localparam int HueWidth  = 10;
   localparam int ChanWidth = 8;
   localparam int RemWidth  = 6;
   localparam int SecWidth  = 3;
   localparam int ScaleWidth = 14;
   localparam int ProdWidth  = ChanWidth + ScaleWidth;
   localparam int RecipShift = 38;
   localparam int RecipWidth = 25;
   localparam int QuotWidth  = ProdWidth + RecipWidth;

   localparam logic [HueWidth-1:0]   DegFull   = HueWidth'(360);
   localparam logic [HueWidth-1:0]   DegSector = HueWidth'(60);
   localparam logic [ChanWidth-1:0]  ChanMax   = 8'd255;
   localparam logic [ScaleWidth-1:0] ScaleQt   = ScaleWidth'(15300);

   // ceil(2^38 / 15300); exact floor division for every product below 2^22
   localparam logic [63:0] RecipFull = ((64'd1 << RecipShift) + 64'd15299) / 64'd15300;
   localparam logic [RecipWidth-1:0] RecipQt = RecipFull[RecipWidth-1:0];

   localparam int GreenShift = 8;
   localparam int BlueShift  = 16;

   typedef logic [SecWidth-1:0] sector_type;

   // Start of each 60 degree sector
   function automatic logic [HueWidth-1:0] sector_base(input sector_type sec);
      logic [HueWidth-1:0] base;
      case (sec)
         3'd0:    base = HueWidth'(0);
         3'd1:    base = HueWidth'(60);
         3'd2:    base = HueWidth'(120);
         3'd3:    base = HueWidth'(180);
         3'd4:    base = HueWidth'(240);
         3'd5:    base = HueWidth'(300);
         default: base = HueWidth'(0);
      endcase
      return base;
   endfunction

endpackage

// File: design/hsv_to_rgb_pixel.sv
// HSV to RGB pixel converter: five-stage pipeline with a stream interface.
// Throughput: one request per cycle; the multiply and reciprocal-divide stages set the depth.
// A stall at the result side holds every stage in place; req_tready drops with it.
// Reset (synchronous, active high) clears all stage valid bits; data registers are not reset.
module hsv_to_rgb_pixel
   import hsv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // hue [9:0], saturation [17:10], brightness [25:18]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // packed_colour [23:0]
);

   logic advance;

   logic [HueWidth-1:0]  hue;
   logic [ChanWidth-1:0] sat;
   logic [ChanWidth-1:0] val;
   logic [HueWidth-1:0]  hue_eff;
   sector_type           sec_in;
   logic [HueWidth-1:0]  rem_full;

   // stage 1
   logic                  v1_ff;
   sector_type            sec1_ff;
   logic [RemWidth-1:0]   rem1_ff;
   logic [ChanWidth-1:0]  sat1_ff, val1_ff;
   logic                  blk1_ff;
   logic [2*ChanWidth-1:0] np1_ff, np1_in;

   // stage 2
   logic                  v2_ff;
   sector_type            sec2_ff;
   logic [ChanWidth-1:0]  val2_ff, p2_ff, p2_in;
   logic                  blk2_ff;
   logic [ScaleWidth-1:0] aq2_ff, at2_ff, aq2_in, at2_in;
   logic [ScaleWidth:0]   sr_full, st_full;
   logic [RemWidth:0]     rem_comp;
   logic [2*ChanWidth:0]  pdiv_sum;

   // stage 3
   logic                  v3_ff;
   sector_type            sec3_ff;
   logic [ChanWidth-1:0]  val3_ff, p3_ff;
   logic                  blk3_ff;
   logic [ProdWidth-1:0]  mq3_ff, mt3_ff;

   // stage 4
   logic                  v4_ff;
   sector_type            sec4_ff;
   logic [ChanWidth-1:0]  val4_ff, p4_ff;
   logic                  blk4_ff;
   logic [QuotWidth-1:0]  rq4_ff, rt4_ff;

   // stage 5 (output)
   logic                  v5_ff;
   logic [23:0]           rgb5_ff, rgb5_in;
   logic [ChanWidth-1:0]  q5, t5, r5, g5, b5;

   assign advance    = ~v5_ff | rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = rgb5_ff;

   assign hue = req_tdata[HueWidth-1:0];
   assign sat = req_tdata[HueWidth+ChanWidth-1:HueWidth];
   assign val = req_tdata[HueWidth+2*ChanWidth-1:HueWidth+ChanWidth];

   // Stage 1: fold 360 to 0, find the sector, start p
   always_comb begin
      hue_eff = (hue == DegFull) ? '0 : hue;
      sec_in  = SecWidth'(32'(hue_eff >= DegSector) + 32'(hue_eff >= 2 * DegSector)
                + 32'(hue_eff >= 3 * DegSector) + 32'(hue_eff >= 4 * DegSector)
                + 32'(hue_eff >= 5 * DegSector));
      rem_full = hue_eff - sector_base(sec_in);
      np1_in   = val * (ChanMax - sat);
   end

   // Stage 2: q and t scale terms, p = np / 255
   always_comb begin
      rem_comp = (RemWidth+1)'(DegSector) - {1'b0, rem1_ff};
      sr_full  = (ScaleWidth+1)'(sat1_ff) * (ScaleWidth+1)'(rem1_ff);
      st_full  = (ScaleWidth+1)'(sat1_ff) * (ScaleWidth+1)'(rem_comp);
      aq2_in   = ScaleQt - sr_full[ScaleWidth-1:0];
      at2_in   = ScaleQt - st_full[ScaleWidth-1:0];
      pdiv_sum = {1'b0, np1_ff} + (2*ChanWidth+1)'(np1_ff >> ChanWidth) + 1'b1;
      p2_in    = pdiv_sum[2*ChanWidth-1:ChanWidth];
   end

   // Stage 5: finish the divides, route channels by sector, zero the pixel for a hue above 360
   always_comb begin
      q5 = rq4_ff[RecipShift+ChanWidth-1:RecipShift];
      t5 = rt4_ff[RecipShift+ChanWidth-1:RecipShift];
      case (sec4_ff)
         3'd0:    begin r5 = val4_ff; g5 = t5;      b5 = p4_ff;   end
         3'd1:    begin r5 = q5;      g5 = val4_ff; b5 = p4_ff;   end
         3'd2:    begin r5 = p4_ff;   g5 = val4_ff; b5 = t5;      end
         3'd3:    begin r5 = p4_ff;   g5 = q5;      b5 = val4_ff; end
         3'd4:    begin r5 = t5;      g5 = p4_ff;   b5 = val4_ff; end
         3'd5:    begin r5 = val4_ff; g5 = p4_ff;   b5 = q5;      end
         default: begin r5 = '0;      g5 = '0;      b5 = '0;      end
      endcase
      if (blk4_ff) begin
         rgb5_in = '0;
      end else begin
         rgb5_in = ({16'd0, r5}) | ({16'd0, g5} << GreenShift) | ({16'd0, b5} << BlueShift);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sec1_ff <= sec_in;
         rem1_ff <= rem_full[RemWidth-1:0];
         sat1_ff <= sat;
         val1_ff <= val;
         blk1_ff <= (hue > DegFull);
         np1_ff  <= np1_in;

         sec2_ff <= sec1_ff;
         val2_ff <= val1_ff;
         blk2_ff <= blk1_ff;
         p2_ff   <= p2_in;
         aq2_ff  <= aq2_in;
         at2_ff  <= at2_in;

         sec3_ff <= sec2_ff;
         val3_ff <= val2_ff;
         blk3_ff <= blk2_ff;
         p3_ff   <= p2_ff;
         mq3_ff  <= val2_ff * aq2_ff;
         mt3_ff  <= val2_ff * at2_ff;

         sec4_ff <= sec3_ff;
         val4_ff <= val3_ff;
         blk4_ff <= blk3_ff;
         p4_ff   <= p3_ff;
         rq4_ff  <= mq3_ff * RecipQt;
         rt4_ff  <= mt3_ff * RecipQt;

         rgb5_ff <= rgb5_in;
      end
   end

endmodule
